// ===== hw/rtl/nzbb_pkg.sv =====
// ----------------------------------------------------------------------------
// nzbb_pkg
// shared types, widths and helpers of the nonzero bounding box core
// ----------------------------------------------------------------------------
`default_nettype none

package nzbb_pkg;

  localparam int MAX_SIDE = 512;
  localparam int SIDE_W   = $clog2(MAX_SIDE);
  localparam int CFG_W    = 10;
  localparam int IDX_W    = 2;
  localparam int VOXEL_W  = 16;
  localparam int MARGIN   = 2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_COLUMNS = 2'd0;
  localparam logic [IDX_W-1:0] REG_ROWS    = 2'd1;
  localparam logic [IDX_W-1:0] REG_LAYERS  = 2'd2;

  // last index of each axis, i.e. size minus one
  typedef struct packed {
    logic [SIDE_W-1:0] col;
    logic [SIDE_W-1:0] row;
    logic [SIDE_W-1:0] layer;
  } lim_t;

  // configuration side to tracker
  typedef struct packed {
    logic restart;
    lim_t lim;
    lim_t lim_nxt;
  } cfg_ctl_t;

  typedef struct packed {
    logic [SIDE_W-1:0] col_start;
    logic [SIDE_W-1:0] col_end;
    logic [SIDE_W-1:0] row_start;
    logic [SIDE_W-1:0] row_end;
    logic [SIDE_W-1:0] layer_start;
    logic [SIDE_W-1:0] layer_end;
    logic              found_any;
  } box_t;

  localparam logic [SIDE_W-1:0] LIM_RESET  = SIDE_W'(256 - 1);
  localparam logic [CFG_W-1:0]  CFG_MAX    = CFG_W'(MAX_SIDE);
  localparam logic [SIDE_W-1:0] SIDE_MAXM1 = SIDE_W'(MAX_SIDE - 1);

  // size register to last index: zero acts as one, large values saturate
  function automatic logic [SIDE_W-1:0] last_index(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] m1;
    m1 = v - CFG_W'(1);
    if (v == '0) begin
      last_index = '0;
    end else if (v > CFG_MAX) begin
      last_index = SIDE_MAXM1;
    end else begin
      last_index = m1[SIDE_W-1:0];
    end
  endfunction

  function automatic logic [SIDE_W-1:0] widen_start(input logic [SIDE_W-1:0] lo);
    if (lo >= SIDE_W'(MARGIN)) begin
      widen_start = lo - SIDE_W'(MARGIN);
    end else begin
      widen_start = '0;
    end
  endfunction

  // end+2 if end < size-3, else size-1 (m is size-1)
  function automatic logic [SIDE_W-1:0] widen_end(input logic [SIDE_W-1:0] hi,
                                                  input logic [SIDE_W-1:0] m);
    logic [SIDE_W:0] grown;
    grown = {1'b0, hi} + (SIDE_W+1)'(MARGIN);
    if (grown < {1'b0, m}) begin
      widen_end = grown[SIDE_W-1:0];
    end else begin
      widen_end = m;
    end
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/nonzero_bounding_box_3d_core.sv =====
// ----------------------------------------------------------------------------
// nonzero_bounding_box_3d_core
// bounding box of the nonzero voxels of a streamed 3D volume
// ----------------------------------------------------------------------------
// Voxels arrive in raster order (column fastest, then row, then layer), one
// per in_ transfer, and the core counts the coordinates itself from the
// configured sizes. After the last voxel of a volume it offers one result:
// the box of all nonzero voxels, widened by two on each side and clamped to
// the volume, plus found_any. An empty volume still gives a result, built
// from the untouched trackers. Throughput is one voxel per clock, set by
// the compare-and-select update of the trackers, unless a last voxel waits
// for the result register; a result reaches out_ through the input register,
// which holds its last voxel, and then the result register, into which the
// box is loaded. A stalled result does not stop the
// stream: voxels that end no volume keep flowing, and only a volume's last
// voxel waits for the result register. Sizes of zero act as one, sizes above
// 512 saturate. Any write to a size register drops the volume in progress
// and starts afresh under the new sizes; write only while the core is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module nonzero_bounding_box_3d_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,

  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [nzbb_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [nzbb_pkg::CFG_W-1:0]   cfg_data,

  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [nzbb_pkg::VOXEL_W-1:0] in_voxel_value,

  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [nzbb_pkg::SIDE_W-1:0]       out_col_start,
  output logic [nzbb_pkg::SIDE_W-1:0]       out_col_end,
  output logic [nzbb_pkg::SIDE_W-1:0]       out_row_start,
  output logic [nzbb_pkg::SIDE_W-1:0]       out_row_end,
  output logic [nzbb_pkg::SIDE_W-1:0]       out_layer_start,
  output logic [nzbb_pkg::SIDE_W-1:0]       out_layer_end,
  output logic                              out_found_any
);

  nzbb_pkg::cfg_ctl_t ctl;
  nzbb_pkg::box_t     box;
  nzbb_pkg::box_t     box_r;

  // input register
  logic                         s1_valid_r;
  logic [nzbb_pkg::VOXEL_W-1:0] s1_voxel_r;
  logic                         out_valid_r;
  logic                         last;
  logic                         s1_adv;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  nzbb_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .ctl      (ctl)
  );

  nzbb_track u_track (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .step  (s1_adv),
    .voxel (s1_voxel_r),
    .last  (last),
    .box   (box)
  );

  // a voxel leaves the input register unless it closes a volume and the
  // result register is still occupied
  assign s1_adv   = s1_valid_r && (!last || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_voxel_r <= in_voxel_value;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && last) begin
      box_r <= box;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_col_start   = box_r.col_start;
  assign out_col_end     = box_r.col_end;
  assign out_row_start   = box_r.row_start;
  assign out_row_end     = box_r.row_end;
  assign out_layer_start = box_r.layer_start;
  assign out_layer_end   = box_r.layer_end;
  assign out_found_any   = box_r.found_any;

endmodule

`default_nettype wire

// ===== hw/rtl/nzbb_cfg.sv =====
// ----------------------------------------------------------------------------
// nzbb_cfg
// size registers, held as last index per axis, and volume restart on write
// ----------------------------------------------------------------------------
`default_nettype none

module nzbb_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       wr_en,
  input  wire logic [nzbb_pkg::IDX_W-1:0] wr_index,
  input  wire logic [nzbb_pkg::CFG_W-1:0] wr_data,
  output nzbb_pkg::cfg_ctl_t              ctl
);

  nzbb_pkg::lim_t lim_r;
  nzbb_pkg::lim_t lim_nxt;
  logic           restart;

  always_comb begin
    lim_nxt = lim_r;
    restart = 1'b0;
    if (wr_en) begin
      case (wr_index)
        nzbb_pkg::REG_COLUMNS: begin
          lim_nxt.col = nzbb_pkg::last_index(wr_data);
          restart     = 1'b1;
        end
        nzbb_pkg::REG_ROWS: begin
          lim_nxt.row = nzbb_pkg::last_index(wr_data);
          restart     = 1'b1;
        end
        nzbb_pkg::REG_LAYERS: begin
          lim_nxt.layer = nzbb_pkg::last_index(wr_data);
          restart       = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r.col   <= nzbb_pkg::LIM_RESET;
      lim_r.row   <= nzbb_pkg::LIM_RESET;
      lim_r.layer <= nzbb_pkg::LIM_RESET;
    end else begin
      lim_r <= lim_nxt;
    end
  end

  assign ctl.restart = restart;
  assign ctl.lim     = lim_r;
  assign ctl.lim_nxt = lim_nxt;

endmodule

`default_nettype wire

// ===== hw/rtl/nzbb_track.sv =====
// ----------------------------------------------------------------------------
// nzbb_track
// raster coordinate counters, min/max trackers and widened box of a volume
// ----------------------------------------------------------------------------
`default_nettype none

module nzbb_track (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire nzbb_pkg::cfg_ctl_t           ctl,
  input  wire logic                         step,
  input  wire logic [nzbb_pkg::VOXEL_W-1:0] voxel,
  output logic                              last,
  output nzbb_pkg::box_t                    box
);

  localparam int W = nzbb_pkg::SIDE_W;

  logic [W-1:0] col_idx_r, row_idx_r, layer_idx_r;
  logic [W-1:0] col_lo_r, col_hi_r, row_lo_r, row_hi_r, layer_lo_r, layer_hi_r;
  logic         seen_r;

  logic [W-1:0] col_lo_nxt, col_hi_nxt, row_lo_nxt, row_hi_nxt;
  logic [W-1:0] layer_lo_nxt, layer_hi_nxt;
  logic         seen_nxt;
  logic         hit, col_wrap, row_wrap;

  assign hit      = (voxel != '0);
  assign col_wrap = (col_idx_r >= ctl.lim.col);
  assign row_wrap = (row_idx_r >= ctl.lim.row);
  assign last     = col_wrap && row_wrap && (layer_idx_r >= ctl.lim.layer);

  always_comb begin
    col_lo_nxt   = (hit && col_idx_r < col_lo_r)     ? col_idx_r   : col_lo_r;
    col_hi_nxt   = (hit && col_idx_r > col_hi_r)     ? col_idx_r   : col_hi_r;
    row_lo_nxt   = (hit && row_idx_r < row_lo_r)     ? row_idx_r   : row_lo_r;
    row_hi_nxt   = (hit && row_idx_r > row_hi_r)     ? row_idx_r   : row_hi_r;
    layer_lo_nxt = (hit && layer_idx_r < layer_lo_r) ? layer_idx_r : layer_lo_r;
    layer_hi_nxt = (hit && layer_idx_r > layer_hi_r) ? layer_idx_r : layer_hi_r;
    seen_nxt     = seen_r | hit;
  end

  always_comb begin
    box.col_start   = nzbb_pkg::widen_start(col_lo_nxt);
    box.col_end     = nzbb_pkg::widen_end(col_hi_nxt, ctl.lim.col);
    box.row_start   = nzbb_pkg::widen_start(row_lo_nxt);
    box.row_end     = nzbb_pkg::widen_end(row_hi_nxt, ctl.lim.row);
    box.layer_start = nzbb_pkg::widen_start(layer_lo_nxt);
    box.layer_end   = nzbb_pkg::widen_end(layer_hi_nxt, ctl.lim.layer);
    box.found_any   = seen_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_idx_r   <= '0;
      row_idx_r   <= '0;
      layer_idx_r <= '0;
      col_lo_r    <= nzbb_pkg::LIM_RESET;
      row_lo_r    <= nzbb_pkg::LIM_RESET;
      layer_lo_r  <= nzbb_pkg::LIM_RESET;
      col_hi_r    <= '0;
      row_hi_r    <= '0;
      layer_hi_r  <= '0;
      seen_r      <= 1'b0;
    end else if (ctl.restart || (step && last)) begin
      // fresh volume; a size write takes the new limits at once
      col_idx_r   <= '0;
      row_idx_r   <= '0;
      layer_idx_r <= '0;
      col_lo_r    <= ctl.lim_nxt.col;
      row_lo_r    <= ctl.lim_nxt.row;
      layer_lo_r  <= ctl.lim_nxt.layer;
      col_hi_r    <= '0;
      row_hi_r    <= '0;
      layer_hi_r  <= '0;
      seen_r      <= 1'b0;
    end else if (step) begin
      col_lo_r   <= col_lo_nxt;
      col_hi_r   <= col_hi_nxt;
      row_lo_r   <= row_lo_nxt;
      row_hi_r   <= row_hi_nxt;
      layer_lo_r <= layer_lo_nxt;
      layer_hi_r <= layer_hi_nxt;
      seen_r     <= seen_nxt;
      if (col_wrap) begin
        col_idx_r <= '0;
        if (row_wrap) begin
          row_idx_r   <= '0;
          layer_idx_r <= layer_idx_r + W'(1);
        end else begin
          row_idx_r <= row_idx_r + W'(1);
        end
      end else begin
        col_idx_r <= col_idx_r + W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/nzbb_checker.sv =====
// ----------------------------------------------------------------------------
// nzbb_checker
// port-level checks of the nonzero bounding box core
// ----------------------------------------------------------------------------
`default_nettype none

module nzbb_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [nzbb_pkg::SIDE_W-1:0]       out_col_start,
  input wire logic [nzbb_pkg::SIDE_W-1:0]       out_col_end,
  input wire logic [nzbb_pkg::SIDE_W-1:0]       out_row_start,
  input wire logic [nzbb_pkg::SIDE_W-1:0]       out_row_end,
  input wire logic [nzbb_pkg::SIDE_W-1:0]       out_layer_start,
  input wire logic [nzbb_pkg::SIDE_W-1:0]       out_layer_end,
  input wire logic                              out_found_any
);

  // no result straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_col_start)
      && $stable(out_col_end) && $stable(out_row_start) && $stable(out_row_end)
      && $stable(out_layer_start) && $stable(out_layer_end)
      && $stable(out_found_any))
    else $error("stalled result changed");

  // an occupied volume gives a proper box on every axis
  a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found_any |-> out_col_start <= out_col_end
      && out_row_start <= out_row_end && out_layer_start <= out_layer_end)
    else $error("box start beyond box end");

  // an empty volume widens from end trackers left at zero
  a_empty_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found_any |-> out_col_end <= 9'd2
      && out_row_end <= 9'd2 && out_layer_end <= 9'd2)
    else $error("empty volume with grown box end");

endmodule

bind nonzero_bounding_box_3d_core nzbb_checker u_nzbb_checker (.*);

`default_nettype wire
